FILE: rtl/core/hcs_pkg.sv
package hcs_pkg;

  // Number of graph vertices.
  localparam int VERTICES = 8;

  // Bits needed for a vertex number and for a count from 0 to VERTICES.
  localparam int VIDX_W = $clog2(VERTICES);
  localparam int CNT_W  = $clog2(VERTICES + 1);

  // Fixed field widths of the transactions.
  localparam int ROW_W    = 8;
  localparam int VERTEX_W = 3;

  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic             row_last;
  } hcs_row_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                found;
    logic                last;
  } hcs_res_t;

  // Status from the search sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } hcs_stat_t;

endpackage

FILE: rtl/core/hcs_adj_store.sv
module hcs_adj_store
  import hcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [ROW_W-1:0]    wr_row,
  input  logic                clear,
  input  logic [VIDX_W-1:0]   rd_addr,
  output logic [VERTICES-1:0] rd_row
);

  logic [VERTICES-1:0] adj [VERTICES];
  logic [CNT_W-1:0]    row_count;

  // Rows past the last vertex are dropped and the count saturates.
  always_ff @(posedge clk) begin
    if (wr_en && (row_count < CNT_W'(VERTICES))) begin
      adj[row_count[VIDX_W-1:0]] <= VERTICES'(wr_row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_count <= '0;
    end else if (wr_en && (row_count < CNT_W'(VERTICES))) begin
      row_count <= row_count + 1'b1;
    end
  end

  assign rd_row = adj[rd_addr];

endmodule

FILE: rtl/core/hcs_search.sv
module hcs_search
  import hcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic [VIDX_W-1:0]   adj_addr,
  input  logic [VERTICES-1:0] adj_row,
  input  logic                out_free,
  output logic                emit,
  output hcs_res_t            emit_item,
  output hcs_stat_t           stat
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;
  localparam logic [1:0] S_FAIL   = 2'd3;

  logic [1:0]          state;
  logic [VIDX_W-1:0]   path [VERTICES];
  logic [VERTICES-1:0] mask;
  logic [CNT_W-1:0]    depth;
  logic [CNT_W-1:0]    cand;
  logic [CNT_W-1:0]    idx;

  logic [CNT_W-1:0]    depth_m1;
  logic [VIDX_W-1:0]   rd_addr;
  logic [VIDX_W-1:0]   last_v;
  logic                emit_last;

  assign depth_m1  = depth - 1'b1;
  assign emit_last = (idx == CNT_W'(VERTICES));

  // One read port on the path: the top of the path while searching,
  // the output position while streaming the cycle out.
  always_comb begin
    if (state == S_EMIT) begin
      rd_addr = emit_last ? '0 : idx[VIDX_W-1:0];
    end else begin
      rd_addr = depth_m1[VIDX_W-1:0];
    end
  end

  assign last_v   = path[rd_addr];
  assign adj_addr = last_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mask  <= '0;
      depth <= '0;
      cand  <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            path[0] <= '0;
            mask    <= VERTICES'(1);
            depth   <= CNT_W'(1);
            cand    <= CNT_W'(1);
            state   <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if ((depth == CNT_W'(VERTICES)) && adj_row[0]) begin
            idx   <= '0;
            state <= S_EMIT;
          end else if ((depth < CNT_W'(VERTICES)) && (cand < CNT_W'(VERTICES))) begin
            if (adj_row[cand[VIDX_W-1:0]] && !mask[cand[VIDX_W-1:0]]) begin
              path[depth[VIDX_W-1:0]] <= cand[VIDX_W-1:0];
              mask[cand[VIDX_W-1:0]]  <= 1'b1;
              depth                   <= depth + 1'b1;
              cand                    <= CNT_W'(1);
            end else begin
              cand <= cand + 1'b1;
            end
          end else if (depth <= CNT_W'(1)) begin
            state <= S_FAIL;
          end else begin
            // Undo the latest choice and resume just after it.
            depth        <= depth_m1;
            mask[last_v] <= 1'b0;
            cand         <= CNT_W'(last_v) + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            idx <= idx + 1'b1;
            if (emit_last) begin
              mask  <= '0;
              depth <= '0;
              state <= S_IDLE;
            end
          end
        end
        S_FAIL: begin
          if (out_free) begin
            mask  <= '0;
            depth <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    emit_item = '0;
    emit      = 1'b0;
    if (state == S_EMIT) begin
      emit             = out_free;
      emit_item.vertex = VERTEX_W'(last_v);
      emit_item.found  = 1'b1;
      emit_item.last   = emit_last;
    end else if (state == S_FAIL) begin
      emit           = out_free;
      emit_item.last = 1'b1;
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = emit && emit_item.last;

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (depth >= CNT_W'(1)) && (depth <= CNT_W'(VERTICES)))
    else $error("search depth out of range");

  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> ($countones(mask) == int'(depth)) && mask[0])
    else $error("on-path mask does not match search depth");

  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    emit |-> (state == S_EMIT) || (state == S_FAIL))
    else $error("result issued outside an output state");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (start && (state == S_IDLE)) |=> (state == S_SEARCH) && (depth == CNT_W'(1)))
    else $error("search did not start");

endmodule

FILE: rtl/core/hamiltonian_cycle_search.sv
// Hamiltonian cycle search over a directed graph of VERTICES vertices.
// The row channel (row_valid, row_stall, row) carries the adjacency matrix,
// one row per transaction starting at row 0; bit j of row_bits marks an edge
// to vertex j. Rows load at one per cycle while row_stall is low. A
// transaction with row_last set starts a depth-first backtracking search
// from vertex 0; rows beyond VERTICES in one load are dropped.
// The search runs one step per cycle on a single sequencer: each step tests
// one candidate vertex against the adjacency row of the path top, pushes it,
// or pops the path. The number of such steps depends on the graph.
// row_stall stays high from the cycle after the last row until the final
// result has entered the output register.
// The result channel (res_valid, res_stall, res) then gives the cycle as
// VERTICES+1 transactions, vertex 0 first and vertex 0 again last, with found
// set, or one transaction with found clear when no cycle exists; last marks
// the final one. Results follow one per cycle while res_stall is low; a stall
// holds the output register and pauses the stream.
// Reset clears the row count, the search state and the output valid; the
// adjacency rows are undefined until loaded.
module hamiltonian_cycle_search
  import hcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     row_valid,
  output logic     row_stall,
  input  hcs_row_t row,
  output logic     res_valid,
  input  logic     res_stall,
  output hcs_res_t res
);

  logic                row_take;
  logic                start;
  logic                out_free;
  logic                emit;
  hcs_res_t            emit_item;
  hcs_stat_t           stat;
  logic [VIDX_W-1:0]   adj_addr;
  logic [VERTICES-1:0] adj_row;

  assign row_stall = stat.busy;
  assign row_take  = row_valid && !row_stall;
  assign start     = row_take && row.row_last;
  assign out_free  = !res_valid || !res_stall;

  hcs_adj_store u_adj (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (row_take),
    .wr_row  (row.row_bits),
    .clear   (stat.done),
    .rd_addr (adj_addr),
    .rd_row  (adj_row)
  );

  hcs_search u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .adj_addr  (adj_addr),
    .adj_row   (adj_row),
    .out_free  (out_free),
    .emit      (emit),
    .emit_item (emit_item),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_item;
    end
  end

endmodule
